>>> rtl/rsbk_pkg.sv
// shared types and constants for the record sort block
// no dependencies; used by the interfaces, the record store and the top level
package rsbk_pkg;

  // field widths of the record and result words
  localparam int unsigned KEY_W  = 31;
  localparam int unsigned TAG_W  = 48;
  localparam int unsigned SUM_W  = 37;
  localparam int unsigned RANK_W = 7;

  // default record capacity
  localparam int unsigned DEPTH_DEF = 64;

  // one stored record: sort key and packed tag
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

endpackage

>>> rtl/rsbk_in_if.sv
// valid/ready channel that carries one input record word
// depends on rsbk_pkg for the field widths
interface rsbk_in_if;
  logic                        valid;
  logic                        ready;
  logic [rsbk_pkg::KEY_W-1:0]  head_count;
  logic [rsbk_pkg::TAG_W-1:0]  area_tag;
  logic                        final_record;

  modport source (output valid, output head_count, output area_tag, output final_record,
                  input ready);
  modport sink   (input valid, input head_count, input area_tag, input final_record,
                  output ready);
endinterface

>>> rtl/rsbk_out_if.sv
// valid/ready channel that carries one sorted result word
// depends on rsbk_pkg for the field widths
interface rsbk_out_if;
  logic                        valid;
  logic                        ready;
  logic [rsbk_pkg::RANK_W-1:0] rank;
  logic [rsbk_pkg::KEY_W-1:0]  sorted_count;
  logic [rsbk_pkg::TAG_W-1:0]  sorted_tag;
  logic [rsbk_pkg::SUM_W-1:0]  grand_total;
  logic                        overflowed;
  logic                        end_of_list;

  modport source (output valid, output rank, output sorted_count, output sorted_tag,
                  output grand_total, output overflowed, output end_of_list,
                  input ready);
  modport sink   (input valid, input rank, input sorted_count, input sorted_tag,
                  input grand_total, input overflowed, input end_of_list,
                  output ready);
endinterface

>>> rtl/rsbk_store.sv
// record store: one write port, one read port, registered read data
// depends on rsbk_pkg for the record type
module rsbk_store #(
  parameter int unsigned DEPTH = rsbk_pkg::DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  rsbk_pkg::rec_t wdata_i,
  input  logic           re_i,
  input  logic [AW-1:0]  raddr_i,
  output rsbk_pkg::rec_t rdata_o
);

  rsbk_pkg::rec_t mem_q [DEPTH];
  rsbk_pkg::rec_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/record_sort_by_key_with_total.sv
// Stable ascending record sorter with a running population total.
// Records come in on rec_i, one word each; the word with final_record set closes
// the set. Each stored record is placed in sorted position at load time: the
// controller walks the store downward from the top entry, one entry a cycle on
// the single read port, moving every strictly larger key up one slot, so equal
// keys keep their load order. A record into an empty store is written as it is
// taken; otherwise it walks the store and is written in ST_SHIFT or ST_PLACE; a
// dropped record (store full) is not written and sets overflowed for the set.
// After the final word the results leave on res_o in rank order, one word per
// stored record, each carrying grand_total and overflowed; the first result is
// read in ST_RD, captured in ST_LOAD and shown in ST_HOLD, and each further
// result is read as the previous one is taken, captured in ST_LOAD and shown in
// ST_HOLD, so a new result is not shown before the previous one is taken.
// res_o is held stable while the receiver stalls; rec_i.ready stays low from the
// final word until the result with end_of_list is taken.
// Reset clears the fill count, total and overflow flag; the store has no reset
// and only entries written in the current set are ever read.
module record_sort_by_key_with_total #(
  parameter int unsigned DEPTH = rsbk_pkg::DEPTH_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  rsbk_in_if.sink    rec_i,
  rsbk_out_if.source res_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FILL_FULL = CW'(DEPTH);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SHIFT = 6'b000010,
    ST_PLACE = 6'b000100,
    ST_RD    = 6'b001000,
    ST_LOAD  = 6'b010000,
    ST_HOLD  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [rsbk_pkg::SUM_W-1:0] sum_q, sum_d;
  logic drop_q, drop_d;
  logic last_q, last_d;
  logic [AW-1:0] j_q, j_d;
  logic [AW-1:0] k_q, k_d;
  rsbk_pkg::rec_t rec_q, rec_d;

  // output payload registers
  logic [rsbk_pkg::RANK_W-1:0] rank_q;
  rsbk_pkg::rec_t out_rec_q;
  logic eol_q;

  // store port signals
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  rsbk_pkg::rec_t mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  rsbk_pkg::rec_t mem_rdata;

  logic acc_in;
  logic acc_out;
  rsbk_pkg::rec_t in_rec;
  state_e done_state;

  assign rec_i.ready = (state_q == ST_IDLE);
  assign acc_in      = rec_i.valid && rec_i.ready;
  assign acc_out     = res_o.valid && res_o.ready;
  assign in_rec      = '{key: rec_i.head_count, tag: rec_i.area_tag};
  assign done_state  = last_q ? ST_RD : ST_IDLE;

  rsbk_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // sequencer: insertion walk while loading, then emission reads
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    sum_d     = sum_q;
    drop_d    = drop_q;
    last_d    = last_q;
    j_d       = j_q;
    k_d       = k_q;
    rec_d     = rec_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rec_q;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state_q)
      ST_IDLE: begin
        if (acc_in) begin
          rec_d  = in_rec;
          last_d = rec_i.final_record;
          k_d    = '0;
          if (fill_q == FILL_FULL) begin
            drop_d  = 1'b1;
            state_d = rec_i.final_record ? ST_RD : ST_IDLE;
          end else begin
            fill_d = fill_q + 1'b1;
            sum_d  = sum_q + rsbk_pkg::SUM_W'(rec_i.head_count);
            if (fill_q == '0) begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = in_rec;
              state_d   = rec_i.final_record ? ST_RD : ST_IDLE;
            end else begin
              // start the walk at the current top entry
              mem_re    = 1'b1;
              mem_raddr = AW'(fill_q - 1'b1);
              j_d       = AW'(fill_q - 1'b1);
              state_d   = ST_SHIFT;
            end
          end
        end
      end
      ST_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = j_q + 1'b1;
        if (mem_rdata.key > rec_q.key) begin
          // move the larger record up, keep walking down or, at entry 0, go to ST_PLACE
          mem_wdata = mem_rdata;
          if (j_q == '0) begin
            state_d = ST_PLACE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = j_q - 1'b1;
            j_d       = j_q - 1'b1;
          end
        end else begin
          mem_wdata = rec_q;
          state_d   = done_state;
        end
      end
      ST_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = rec_q;
        state_d   = done_state;
      end
      ST_RD: begin
        mem_re    = 1'b1;
        mem_raddr = k_q;
        state_d   = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (res_o.ready) begin
          if (eol_q) begin
            fill_d  = '0;
            sum_d   = '0;
            drop_d  = 1'b0;
            state_d = ST_IDLE;
          end else begin
            k_d       = k_q + 1'b1;
            mem_re    = 1'b1;
            mem_raddr = k_q + 1'b1;
            state_d   = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      sum_q   <= '0;
      drop_q  <= 1'b0;
      last_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      sum_q   <= sum_d;
      drop_q  <= drop_d;
      last_q  <= last_d;
      k_q     <= k_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    j_q   <= j_d;
    rec_q <= rec_d;
    if (state_q == ST_LOAD) begin
      out_rec_q <= mem_rdata;
      rank_q    <= rsbk_pkg::RANK_W'(k_q) + rsbk_pkg::RANK_W'(1);
      eol_q     <= (CW'(k_q) + 1'b1) == fill_q;
    end
  end

  // result word
  assign res_o.valid        = (state_q == ST_HOLD);
  assign res_o.rank         = rank_q;
  assign res_o.sorted_count = out_rec_q.key;
  assign res_o.sorted_tag   = out_rec_q.tag;
  assign res_o.grand_total  = sum_q;
  assign res_o.overflowed   = drop_q;
  assign res_o.end_of_list  = eol_q;

  // fill count never passes capacity
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_FULL)
    else $error("fill count above capacity");

  // a result is only shown for a stored entry
  a_rank_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (CW'(k_q) < fill_q))
    else $error("result rank beyond fill count");

  // the store is never written while results are read out
  a_no_write_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_IDLE || state_q == ST_SHIFT || state_q == ST_PLACE))
    else $error("store write during emission");

  // taking the last result closes the set
  a_set_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_out && res_o.end_of_list) |=> (fill_q == '0 && sum_q == '0 && !drop_q))
    else $error("set state not cleared after last result");

endmodule

>>> tb/record_sort_by_key_with_total_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the stable ascending record sorter with population total
// depends on rsbk_pkg, rsbk_in_if, rsbk_out_if and record_sort_by_key_with_total
module record_sort_by_key_with_total_test;

  localparam int unsigned STORE_DEPTH = rsbk_pkg::DEPTH_DEF;
  localparam int unsigned PHASE_WORDS = 138;
  localparam int unsigned DIR_ROWS    = 16;

  // one ranked result word as the sorter should emit it
  typedef struct packed {
    logic [rsbk_pkg::RANK_W-1:0] rank;
    logic [rsbk_pkg::KEY_W-1:0]  count;
    logic [rsbk_pkg::TAG_W-1:0]  tag;
    logic [rsbk_pkg::SUM_W-1:0]  total;
    logic                        ovf;
    logic                        eol;
  } ranked_t;

  // one stimulus row; typed rows carry their single result written out
  typedef struct packed {
    logic [rsbk_pkg::KEY_W-1:0] key;
    logic [rsbk_pkg::TAG_W-1:0] tag;
    logic                       last;
    logic                       typed;
    ranked_t                    want;
  } row_t;

  // key distributions for random sets
  typedef enum int {MIX_WIDE, MIX_TIES, MIX_HIGH} key_mix_e;

  logic clk_i;
  logic rst_ni;

  rsbk_in_if  rec_if ();
  rsbk_out_if res_if ();

  record_sort_by_key_with_total uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rec_i  (rec_if),
    .res_o  (res_if)
  );

  // predictor state for the set being loaded
  rsbk_pkg::rec_t             set_recs[$];
  logic [rsbk_pkg::SUM_W-1:0] set_total;
  bit                         set_dropped;

  // ranked words still owed by the sorter, oldest first
  ranked_t ranks_due[$];
  ranked_t head_due;
  int      fail_count;

  int send_idle_pct;
  int recv_idle_pct;
  int send_pct_by_phase [3] = '{9, 80, 0};
  int recv_pct_by_phase [3] = '{80, 9, 0};

  row_t directed_rows [DIR_ROWS];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // load one record into the predicted set; on the last record rank the set
  function automatic void rank_record(input rsbk_pkg::rec_t r, input bit last,
                                      input bit publish);
    rsbk_pkg::rec_t order[$];
    rsbk_pkg::rec_t moving;
    int             j;
    if (set_recs.size() < STORE_DEPTH) begin
      set_recs.push_back(r);
      set_total = set_total + rsbk_pkg::SUM_W'(r.key);
    end else begin
      set_dropped = 1'b1;
    end
    if (!last) return;
    // insertion sort, moving only past strictly larger keys keeps ties in load order
    order = set_recs;
    for (int i = 1; i < order.size(); i++) begin
      moving = order[i];
      j = i;
      while (j > 0 && order[j-1].key > moving.key) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = moving;
    end
    if (publish) begin
      foreach (order[k]) begin
        ranks_due.push_back('{rank:  rsbk_pkg::RANK_W'(k + 1),
                              count: order[k].key,
                              tag:   order[k].tag,
                              total: set_total,
                              ovf:   set_dropped,
                              eol:   (k == order.size() - 1)});
      end
    end
    set_recs    = {};
    set_total   = '0;
    set_dropped = 1'b0;
  endfunction

  // offer one record word, with random idle cycles ahead of it
  task automatic send_word(input row_t row);
    rsbk_pkg::rec_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      rec_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rec_if.valid        <= 1'b1;
    rec_if.head_count   <= row.key;
    rec_if.area_tag     <= row.tag;
    rec_if.final_record <= row.last;
    do @(posedge clk_i); while (rec_if.ready !== 1'b1);
    r.key = row.key;
    r.tag = row.tag;
    rank_record(r, row.last, !row.typed);
    if (row.typed) ranks_due.push_back(row.want);
  endtask

  // one random set of n records, the last flagged final
  task automatic send_set(input int n, input key_mix_e mix);
    row_t row;
    for (int i = 0; i < n; i++) begin
      case (mix)
        MIX_TIES: row.key = rsbk_pkg::KEY_W'($urandom_range(3));
        MIX_HIGH: row.key = {rsbk_pkg::KEY_W{1'b1}} - rsbk_pkg::KEY_W'($urandom_range(7));
        default:  row.key = rsbk_pkg::KEY_W'($urandom);
      endcase
      row.tag   = rsbk_pkg::TAG_W'({$urandom, $urandom});
      row.last  = (i == n - 1);
      row.typed = 1'b0;
      row.want  = '0;
      send_word(row);
    end
  endtask

  // compare one result field
  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // result side: check each taken word, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (ranks_due.size() == 0) begin
        $error("unexpected result word: rank %0d, sorted_count 'h%0h",
               res_if.rank, res_if.sorted_count);
        fail_count++;
      end else begin
        head_due = ranks_due.pop_front();
        compare_field("rank",         head_due.rank,  res_if.rank);
        compare_field("sorted_count", head_due.count, res_if.sorted_count);
        compare_field("sorted_tag",   head_due.tag,   res_if.sorted_tag);
        compare_field("grand_total",  head_due.total, res_if.grand_total);
        compare_field("overflowed",   head_due.ovf,   res_if.overflowed);
        compare_field("end_of_list",  head_due.eol,   res_if.end_of_list);
      end
    end
    res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // stimulus
  initial begin
    int sent;
    int n;
    directed_rows = '{
      // single record at the top of both fields
      '{31'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1,
        '{7'd1, 31'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 37'h00_7FFF_FFFF, 1'b0, 1'b1}},
      // single record of zeros
      '{31'd0, 48'h0, 1'b1, 1'b1, '{7'd1, 31'd0, 48'h0, 37'd0, 1'b0, 1'b1}},
      // descending keys, full reversal
      '{31'd30, 48'h4D32_4A34_4136, 1'b0, 1'b0, '0},
      '{31'd20, 48'h4C34_4B31_4732, 1'b0, 1'b0, '0},
      '{31'd10, 48'h4B31_4130_4231, 1'b1, 1'b0, '0},
      // equal keys keep their load order
      '{31'd5, 48'h4D32_4A34_4136, 1'b0, 1'b0, '0},
      '{31'd5, 48'h4C34_4B31_4732, 1'b0, 1'b0, '0},
      '{31'd3, 48'h4B31_4130_4231, 1'b0, 1'b0, '0},
      '{31'd5, 48'h4833_5A32_5937, 1'b1, 1'b0, '0},
      // tie at the largest key, total carries past 31 bits
      '{31'h7FFF_FFFF, 48'h5435_4131_4E31, 1'b0, 1'b0, '0},
      '{31'h7FFF_FFFF, 48'h5636_4234_5938, 1'b1, 1'b0, '0},
      // already in order
      '{31'd1, 48'h5030_4831_5630, 1'b0, 1'b0, '0},
      '{31'd2, 48'h5636_4234_5938, 1'b0, 1'b0, '0},
      '{31'd3, 48'h5435_4131_4E31, 1'b1, 1'b0, '0},
      // alternating bit patterns
      '{31'h2AAA_AAAA, 48'h5555_5555_5555, 1'b0, 1'b0, '0},
      '{31'h5555_5555, 48'hAAAA_AAAA_AAAA, 1'b1, 1'b0, '0}
    };

    rst_ni              = 1'b0;
    rec_if.valid        = 1'b0;
    rec_if.head_count   = '0;
    rec_if.area_tag     = '0;
    rec_if.final_record = 1'b0;
    res_if.ready        = 1'b0;
    set_total           = '0;
    set_dropped         = 1'b0;
    fail_count          = 0;
    send_idle_pct       = send_pct_by_phase[0];
    recv_idle_pct       = recv_pct_by_phase[0];

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[i]) send_word(directed_rows[i]);

    // hold off until every owed word has come back
    rec_if.valid <= 1'b0;
    do @(posedge clk_i); while (ranks_due.size() != 0);

    // random sets under three idle patterns; each phase opens with a large set:
    // an exactly full store, then drops including the final word, then a mixed overflow
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = send_pct_by_phase[p];
      recv_idle_pct = recv_pct_by_phase[p];
      case (p)
        0:       begin send_set(STORE_DEPTH,     MIX_HIGH); sent = STORE_DEPTH;     end
        1:       begin send_set(STORE_DEPTH + 2, MIX_TIES); sent = STORE_DEPTH + 2; end
        default: begin send_set(STORE_DEPTH + 6, MIX_WIDE); sent = STORE_DEPTH + 6; end
      endcase
      while (sent < PHASE_WORDS) begin
        n = $urandom_range(10, 1);
        send_set(n, key_mix_e'($urandom_range(2)));
        sent += n;
      end
    end

    // drain, then watch for stray words
    rec_if.valid <= 1'b0;
    do @(posedge clk_i); while (ranks_due.size() != 0);
    repeat (150) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
